FILE: src/assert_macros.svh
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off while reset is asserted.
`define PFDD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfdd assertion failed");

// Implication into the next cycle, off while reset is asserted.
`define PFDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfdd assertion failed");

// Implication into the next cycle, checked in reset as well.
`define PFDD_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pfdd assertion failed");

`endif

FILE: src/pfdd_pkg.sv
// Package: types, constants and width helpers of the PCM frame decoder and downmixer.
package pfdd_pkg;

  localparam int DATA_W        = 8;
  localparam int SAMPLE_W      = 16;
  localparam int INDEX_W       = 16;
  localparam int MAX_FRAMES_W  = 17;
  localparam int CHAN_CODE_W   = 4;
  localparam int WIDTH_CODE_W  = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 17;
  localparam int DIV_STEP_BITS = 4;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_FRAME_LIMIT  = 65536;
  localparam int DEF_QUEUE_DEPTH  = 2;

  // Sample width codes; the unused code decodes as 8-bit unsigned.
  localparam logic [WIDTH_CODE_W-1:0] WIDTH_U8 = 2'd0;
  localparam logic [WIDTH_CODE_W-1:0] WIDTH_16 = 2'd1;
  localparam logic [WIDTH_CODE_W-1:0] WIDTH_24 = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_WIDTH  = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_MAX_FRAMES    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [WIDTH_CODE_W-1:0] sample_width_code;
    logic [CHAN_CODE_W-1:0]  chans_per_frame;
    logic [MAX_FRAMES_W-1:0] max_frame_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sample_width_code: WIDTH_16,
    chans_per_frame:   4'd1,
    max_frame_count:   17'd65536
  };

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              end_of_data;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mono_sample;
    logic [INDEX_W-1:0]         frame_index;
    logic                       final_frame;
  } out_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_WRITE
  } back_state_t;

  // Bits to index a channel position below n.
  function automatic int pos_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Bits to hold a channel count up to n.
  function automatic int cnt_width(input int n);
    return $clog2(n + 1);
  endfunction

  // Bits of a signed sum of up to n decoded samples.
  function automatic int sum_width(input int n);
    return SAMPLE_W + pos_width(n) + 1;
  endfunction

endpackage

FILE: src/pfdd_stream_if.sv
// Valid/ready stream interface with a typed payload.
interface pfdd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/pfdd_front.sv
// Front end: byte assembly, sample decode, frame summing and frame counting.
module pfdd_front #(
  parameter int MAX_CHANNELS = pfdd_pkg::DEF_MAX_CHANNELS,
  parameter int FRAME_LIMIT  = pfdd_pkg::DEF_FRAME_LIMIT,
  localparam int CH_W  = pfdd_pkg::pos_width(MAX_CHANNELS),
  localparam int CNT_W = pfdd_pkg::cnt_width(MAX_CHANNELS),
  localparam int SUM_W = pfdd_pkg::sum_width(MAX_CHANNELS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfdd_pkg::cfg_t                cfg,
  input  logic                          cfg_clear,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pfdd_pkg::in_item_t            in_item,
  input  logic                          q_full,
  output logic                          push,
  output logic signed [SUM_W-1:0]       push_sum,
  output logic [CNT_W-1:0]              push_chans,
  output logic [pfdd_pkg::INDEX_W-1:0]  push_index,
  output logic                          push_final
);
  import pfdd_pkg::*;

  localparam logic [MAX_FRAMES_W-1:0] LIMIT_CAP =
    (FRAME_LIMIT > 131071) ? {MAX_FRAMES_W{1'b1}} : MAX_FRAMES_W'(FRAME_LIMIT);

  logic [1:0]              byte_pos_r, byte_pos_nxt;
  logic [CH_W-1:0]         ch_pos_r, ch_pos_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [MAX_FRAMES_W-1:0] frames_r, frames_nxt;
  logic [DATA_W-1:0]       prev_r;

  logic [CNT_W-1:0]        chans;
  logic [MAX_FRAMES_W-1:0] limit;
  logic [MAX_FRAMES_W-1:0] frames_inc;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SUM_W-1:0] sum_add;
  logic                    last_byte;
  logic                    last_chan;
  logic                    frame_done;
  logic                    emit;
  logic                    accept;

  // Clamp the channel count to 1..MAX_CHANNELS.
  always_comb begin
    if (cfg.chans_per_frame == '0) begin
      chans = CNT_W'(1);
    end else if (5'(cfg.chans_per_frame) > 5'(MAX_CHANNELS)) begin
      chans = CNT_W'(MAX_CHANNELS);
    end else begin
      chans = CNT_W'(cfg.chans_per_frame);
    end
  end

  assign limit = (cfg.max_frame_count > LIMIT_CAP) ? LIMIT_CAP : cfg.max_frame_count;

  always_comb begin
    case (cfg.sample_width_code)
      WIDTH_16: last_byte = (byte_pos_r == 2'd1);
      WIDTH_24: last_byte = (byte_pos_r == 2'd2);
      default:  last_byte = 1'b1;
    endcase
  end

  // 16-bit takes the two bytes as is; 24-bit keeps its upper two bytes.
  always_comb begin
    if (cfg.sample_width_code inside {WIDTH_16, WIDTH_24}) begin
      sample = {in_item.data_byte, prev_r};
    end else begin
      sample = {~in_item.data_byte[DATA_W-1], in_item.data_byte[DATA_W-2:0], 8'h00};
    end
  end

  assign sum_add    = sum_r + SUM_W'(sample);
  assign last_chan  = (CNT_W'(ch_pos_r) == CNT_W'(chans - 1'b1));
  assign frame_done = last_byte && last_chan;
  assign emit       = (frames_r < limit);
  assign frames_inc = frames_r + 1'b1;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign push       = accept && frame_done && emit;
  assign push_sum   = sum_add;
  assign push_chans = chans;
  assign push_index = frames_r[INDEX_W-1:0];
  assign push_final = in_item.end_of_data || (frames_inc == limit);

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    ch_pos_nxt   = ch_pos_r;
    sum_nxt      = sum_r;
    frames_nxt   = frames_r;
    if (cfg_clear) begin
      byte_pos_nxt = '0;
      ch_pos_nxt   = '0;
      sum_nxt      = '0;
    end else if (accept) begin
      if (in_item.end_of_data) begin
        byte_pos_nxt = '0;
        ch_pos_nxt   = '0;
        sum_nxt      = '0;
        frames_nxt   = '0;
      end else if (!last_byte) begin
        byte_pos_nxt = byte_pos_r + 1'b1;
      end else if (frame_done) begin
        byte_pos_nxt = '0;
        ch_pos_nxt   = '0;
        sum_nxt      = '0;
        frames_nxt   = emit ? frames_inc : frames_r;
      end else begin
        byte_pos_nxt = '0;
        ch_pos_nxt   = ch_pos_r + 1'b1;
        sum_nxt      = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      ch_pos_r   <= '0;
      sum_r      <= '0;
      frames_r   <= '0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      ch_pos_r   <= ch_pos_nxt;
      sum_r      <= sum_nxt;
      frames_r   <= frames_nxt;
    end
  end

  // Keep the latest non-final byte of a sample.
  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      prev_r <= in_item.data_byte;
    end
  end

endmodule

FILE: src/pfdd_queue.sv
// Small register queue between the front end and the divider.
module pfdd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pfdd_pkg::DEF_QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: src/pfdd_back.sv
// Back end: signed divide of the frame sum by the channel count, result register.
module pfdd_back #(
  parameter int MAX_CHANNELS = pfdd_pkg::DEF_MAX_CHANNELS,
  localparam int CNT_W  = pfdd_pkg::cnt_width(MAX_CHANNELS),
  localparam int SUM_W  = pfdd_pkg::sum_width(MAX_CHANNELS),
  localparam int ITERS  = (SUM_W + pfdd_pkg::DIV_STEP_BITS - 1) / pfdd_pkg::DIV_STEP_BITS,
  localparam int DIV_W  = ITERS * pfdd_pkg::DIV_STEP_BITS,
  localparam int ITER_W = (ITERS > 1) ? $clog2(ITERS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic signed [SUM_W-1:0]      q_sum,
  input  logic [CNT_W-1:0]             q_chans,
  input  logic [pfdd_pkg::INDEX_W-1:0] q_index,
  input  logic                         q_final,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pfdd_pkg::out_item_t          out_item
);
  import pfdd_pkg::*;

  back_state_t         state_r, state_nxt;
  logic [ITER_W-1:0]   iter_r;
  logic                neg_r;
  logic [CNT_W-1:0]    divisor_r;
  logic [CNT_W-1:0]    rem_r, rem_step;
  logic [DIV_W-1:0]    quo_r, quo_step;
  logic [INDEX_W-1:0]  index_r;
  logic                final_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic                load;
  logic                div_step;
  logic                out_load;
  logic [SUM_W-1:0]    mag;
  logic [SAMPLE_W-1:0] quo_lo;

  assign mag    = q_sum[SUM_W-1] ? (~q_sum + 1'b1) : q_sum;
  assign quo_lo = quo_r[SAMPLE_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (iter_r == ITER_W'(ITERS - 1)) begin
          state_nxt = BK_WRITE;
        end
      end
      BK_WRITE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    load     = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_IDLE:   load     = !q_empty;
      BK_DIVIDE: div_step = 1'b1;
      BK_WRITE:  out_load = !out_valid_r || out_ready;
      default:   load     = 1'b0;
    endcase
  end

  assign q_pop = load;

  // Restoring division, DIV_STEP_BITS quotient bits per cycle.
  always_comb begin
    logic [CNT_W:0] r_ext;
    logic [CNT_W-1:0] r;
    logic [DIV_W-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      r_ext = {r, q[DIV_W-1]};
      q     = {q[DIV_W-2:0], 1'b0};
      if (r_ext >= {1'b0, divisor_r}) begin
        r_ext = r_ext - {1'b0, divisor_r};
        q[0]  = 1'b1;
      end
      r = r_ext[CNT_W-1:0];
    end
    rem_step = r;
    quo_step = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      iter_r    <= '0;
      neg_r     <= q_sum[SUM_W-1];
      divisor_r <= q_chans;
      rem_r     <= '0;
      quo_r     <= DIV_W'(mag);
      index_r   <= q_index;
      final_r   <= q_final;
    end else if (div_step) begin
      iter_r <= iter_r + 1'b1;
      rem_r  <= rem_step;
      quo_r  <= quo_step;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.mono_sample <= neg_r ? (~quo_lo + 1'b1) : quo_lo;
      out_item_r.frame_index <= index_r;
      out_item_r.final_frame <= final_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: src/pcm_frame_decode_downmix_core.sv
// Top level of the PCM frame decoder and mono downmixer.
//
// Takes the bytes of a PCM data chunk, one item per byte, and gives one
// 16-bit mono sample per complete frame with its frame index. Each channel
// sample is assembled little-endian: 8-bit unsigned becomes (b-128)<<8,
// 16-bit is taken as signed, 24-bit keeps its upper two bytes. The channel
// samples of a frame are summed and the sum is divided by the channel count,
// rounding toward zero. Frames past min(max_frame_count, FRAME_LIMIT) are
// parsed but give no result; a byte with end_of_data set is processed, then
// the partial frame and the frame counter are cleared. A configuration write
// to a listed register drops the frame in progress; write only while idle.
// Rate: the front end takes one byte per cycle while the frame queue has
// room. The back end takes one frame at a time through a load state, a
// divide state in which the divider retires four quotient bits per cycle,
// and a write state that waits while an earlier result is still not taken.
// The queue gives QUEUE_DEPTH frames of slack between the two halves.
module pcm_frame_decode_downmix_core #(
  parameter int MAX_CHANNELS = pfdd_pkg::DEF_MAX_CHANNELS,
  parameter int FRAME_LIMIT  = pfdd_pkg::DEF_FRAME_LIMIT,
  parameter int QUEUE_DEPTH  = pfdd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pfdd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pfdd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  pfdd_stream_if.sink                      in_chan,
  pfdd_stream_if.source                    out_chan
);
  import pfdd_pkg::*;

  localparam int CNT_W   = cnt_width(MAX_CHANNELS);
  localparam int SUM_W   = sum_width(MAX_CHANNELS);
  localparam int ENTRY_W = SUM_W + CNT_W + INDEX_W + 1;

  // Configuration registers.
  cfg_t cfg_r, cfg_nxt;
  logic cfg_clear;

  // Front to queue.
  logic                    push;
  logic signed [SUM_W-1:0] push_sum;
  logic [CNT_W-1:0]        push_chans;
  logic [INDEX_W-1:0]      push_index;
  logic                    push_final;
  logic [ENTRY_W-1:0]      q_din;

  // Queue to back.
  logic                    q_full;
  logic                    q_empty;
  logic                    q_pop;
  logic [ENTRY_W-1:0]      q_dout;
  logic signed [SUM_W-1:0] q_sum;
  logic [CNT_W-1:0]        q_chans;
  logic [INDEX_W-1:0]      q_index;
  logic                    q_final;

  // Decode the write; an index past the list changes nothing.
  always_comb begin
    cfg_nxt   = cfg_r;
    cfg_clear = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_WIDTH: begin
          cfg_nxt.sample_width_code = cfg_wdata[WIDTH_CODE_W-1:0];
          cfg_clear                 = 1'b1;
        end
        REG_CHANNEL_COUNT: begin
          cfg_nxt.chans_per_frame = cfg_wdata[CHAN_CODE_W-1:0];
          cfg_clear               = 1'b1;
        end
        REG_MAX_FRAMES: begin
          cfg_nxt.max_frame_count = cfg_wdata[MAX_FRAMES_W-1:0];
          cfg_clear               = 1'b1;
        end
        default: cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pfdd_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAME_LIMIT  (FRAME_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cfg_clear  (cfg_clear),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_item    (in_chan.data),
    .q_full     (q_full),
    .push       (push),
    .push_sum   (push_sum),
    .push_chans (push_chans),
    .push_index (push_index),
    .push_final (push_final)
  );

  // Pack one finished frame sum for the divider.
  assign q_din = {push_sum, push_chans, push_index, push_final};

  pfdd_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {q_sum, q_chans, q_index, q_final} = q_dout;

  pfdd_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_sum     (q_sum),
    .q_chans   (q_chans),
    .q_index   (q_index),
    .q_final   (q_final),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (out_chan.data)
  );

endmodule

FILE: src/pfdd_checker.sv
// Port-level checker of the decoder core, bound to the top level.
`include "assert_macros.svh"

module pfdd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pfdd_pkg::out_item_t out_item
);
  import pfdd_pkg::*;

  logic               have_prev_r;
  logic [INDEX_W-1:0] prev_idx_r;
  logic               out_acc;
  logic               in_acc;

  assign out_acc = out_valid && out_ready;
  assign in_acc  = in_valid && in_ready;

  // Track the index of the last item taken that did not end a run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (out_acc) begin
      have_prev_r <= !out_item.final_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_idx_r <= out_item.frame_index;
    end
  end

  `PFDD_ASSERT_NEXT(a_out_valid_held, out_valid && !out_ready, out_valid)
  `PFDD_ASSERT_NEXT(a_out_item_held, out_valid && !out_ready, $stable(out_item))
  `PFDD_ASSERT_NEXT_ALWAYS(a_reset_no_output, !rst_n, !out_valid)
  `PFDD_ASSERT_NEXT_ALWAYS(a_reset_ready, !rst_n, in_ready || in_acc)
  `PFDD_ASSERT_IMPLY(a_index_order, out_acc && have_prev_r, (out_item.frame_index == INDEX_W'(prev_idx_r + 1'b1)) || (out_item.frame_index == '0))

endmodule

bind pcm_frame_decode_downmix_core pfdd_checker u_pfdd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_item  (out_chan.data)
);

FILE: tb/tb_top.sv
// Self-checking bench for the PCM frame decoder and mono downmixer.
module tb_top;
  import pfdd_pkg::*;

  localparam int REPORT_LIMIT   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int END_CYCLES     = 50;
  localparam int RANDOM_PHASES  = 26;
  localparam int PHASE_ITEMS    = 65;
  localparam int CALM_PHASES    = 3;
  localparam int CHAN_CAP       = DEF_MAX_CHANNELS;
  localparam int FRAME_CAP      = DEF_FRAME_LIMIT;

  // Width code with no format of its own; the block decodes it as 8-bit unsigned.
  localparam logic [WIDTH_CODE_W-1:0] WIDTH_SPARE = 2'd3;
  // Register index past the end of the register list; writes to it are ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNLISTED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pfdd_stream_if #(.payload_t(in_item_t))  in_chan_if ();
  pfdd_stream_if #(.payload_t(out_item_t)) out_chan_if ();

  pcm_frame_decode_downmix_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan_if),
    .out_chan  (out_chan_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the registers and the frame state.
  // ---------------------------------------------------------------------------
  logic [WIDTH_CODE_W-1:0] width_code  = WIDTH_16;
  logic [CHAN_CODE_W-1:0]  chan_code   = 4'd1;
  logic [MAX_FRAMES_W-1:0] frame_cap_r = 17'd65536;

  int          byte_pos    = 0;
  int          chan_pos    = 0;
  logic [23:0] assembly    = '0;
  int          frame_sum   = 0;
  int          frames_done = 0;

  function automatic int sample_bytes();
    if (width_code == WIDTH_16) return 2;
    if (width_code == WIDTH_24) return 3;
    return 1;
  endfunction

  function automatic int active_channels();
    if (chan_code == 0) return 1;
    if (int'(chan_code) > CHAN_CAP) return CHAN_CAP;
    return int'(chan_code);
  endfunction

  function automatic void drop_partial_frame();
    byte_pos  = 0;
    chan_pos  = 0;
    assembly  = '0;
    frame_sum = 0;
  endfunction

  // Mirror a register write; an unlisted index leaves everything as it was.
  function automatic void mirror_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SAMPLE_WIDTH:  width_code  = val[WIDTH_CODE_W-1:0];
      REG_CHANNEL_COUNT: chan_code   = val[CHAN_CODE_W-1:0];
      REG_MAX_FRAMES:    frame_cap_r = val[MAX_FRAMES_W-1:0];
      default:           return;
    endcase
    drop_partial_frame();
  endfunction

  // Advance the frame state by one byte; return 1 with the mono sample when one is due.
  function automatic bit predict_mono_frame(input in_item_t item, output out_item_t res);
    int bps;
    int nch;
    int limit;
    int decoded;
    int avg;
    bit produced;
    bps = sample_bytes();
    nch = active_channels();
    limit = (int'(frame_cap_r) > FRAME_CAP) ? FRAME_CAP : int'(frame_cap_r);
    produced = 1'b0;
    res = '0;

    assembly = assembly | (24'(item.data_byte) << (8 * byte_pos));
    byte_pos++;
    if (byte_pos >= bps) begin
      case (width_code)
        WIDTH_16: decoded = int'($signed(assembly[15:0]));
        WIDTH_24: decoded = int'($signed(assembly[23:8]));
        default:  decoded = (int'(assembly[7:0]) - 128) * 256;
      endcase
      frame_sum += decoded;
      byte_pos = 0;
      assembly = '0;
      chan_pos++;
      if (chan_pos >= nch) begin
        if (frames_done < limit) begin
          avg = frame_sum / nch;  // truncates toward zero
          res.mono_sample = avg[15:0];
          res.frame_index = frames_done[15:0];
          res.final_frame = item.end_of_data || (frames_done + 1 == limit);
          produced = 1'b1;
          frames_done++;
        end
        chan_pos = 0;
        frame_sum = 0;
      end
    end

    // End of data: drop any partial frame and restart the frame count.
    if (item.end_of_data) begin
      drop_partial_frame();
      frames_done = 0;
    end
    return produced;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store, driver and sink.
  // ---------------------------------------------------------------------------
  in_item_t  byte_backlog[$];
  out_item_t mono_expected[$];
  int        bytes_queued = 0;
  int        bytes_taken  = 0;
  int        failures     = 0;
  int        quiet_cycles = 0;
  bit        idling_on    = 1'b1;
  bit        byte_taken   = 1'b0;
  int        send_gap     = 0;
  int        sink_stall   = 0;
  out_item_t mono_want;
  out_item_t mono_got;
  out_item_t mono_next;

  initial begin
    in_chan_if.valid = 1'b0;
    in_chan_if.data  = '0;
    out_chan_if.ready = 1'b0;
  end

  // Hold an item until it is taken; between items, idle in random bursts while idling is on.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan_if.valid <= 1'b0;
    end else if (!(in_chan_if.valid && !byte_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_chan_if.valid <= 1'b0;
      end else if (byte_backlog.size() == 0) begin
        in_chan_if.valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 6);
        in_chan_if.valid <= 1'b0;
      end else begin
        in_chan_if.data  <= byte_backlog.pop_front();
        in_chan_if.valid <= 1'b1;
      end
    end
  end

  // Stall the result side in random bursts while idling is on.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan_if.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_chan_if.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(0, 6);
      out_chan_if.ready <= 1'b0;
    end else begin
      out_chan_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every taken byte, check every taken result, watch for hangs.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_taken <= rst_n && in_chan_if.valid && in_chan_if.ready;

    if (rst_n && in_chan_if.valid && in_chan_if.ready) begin
      bytes_taken++;
      if (predict_mono_frame(in_chan_if.data, mono_next)) mono_expected.push_back(mono_next);
    end

    if (rst_n && out_chan_if.valid && out_chan_if.ready) begin
      mono_got = out_chan_if.data;
      if (mono_expected.size() == 0) begin
        if (failures < REPORT_LIMIT)
          $display("unexpected result: sample %0d index %0d final %0b",
                   mono_got.mono_sample, mono_got.frame_index, mono_got.final_frame);
        failures++;
      end else begin
        mono_want = mono_expected.pop_front();
        if (mono_got.mono_sample !== mono_want.mono_sample ||
            mono_got.frame_index !== mono_want.frame_index ||
            mono_got.final_frame !== mono_want.final_frame) begin
          if (failures < REPORT_LIMIT)
            $display("mismatch: sample %0d/%0d index %0d/%0d final %0b/%0b (exp/got)",
                     mono_want.mono_sample, mono_got.mono_sample,
                     mono_want.frame_index, mono_got.frame_index,
                     mono_want.final_frame, mono_got.final_frame);
          failures++;
        end
      end
    end

    // Restart the hang counter on any handshake or register write.
    if ((in_chan_if.valid && in_chan_if.ready) || (out_chan_if.valid && out_chan_if.ready) ||
        cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input bit eod);
    in_item_t item;
    item.data_byte   = b;
    item.end_of_data = eod;
    byte_backlog.push_back(item);
    bytes_queued++;
  endtask

  // Bias three eighths of the bytes toward the edges of the sample range.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Write one register on the next falling edge and mirror it in the predictor.
  task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    mirror_reg_write(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every byte is taken and every result is in, then let the
  // block settle before the next register writes.
  task automatic wait_block_idle();
    while (bytes_taken != bytes_queued || mono_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Queue a phase of exactly n_items bytes: mostly whole-frame streams with
  // random content, lone noise bytes and streams that end mid-frame; cut the
  // last stream short to hold the count.
  task automatic queue_random_phase(input int n_items);
    int fb;
    int pushed;
    int cut;
    int total;
    fb = sample_bytes() * active_channels();
    pushed = 0;
    while (pushed < n_items) begin
      case ($urandom_range(0, 9))
        0: begin
          push_byte(pick_byte(), $urandom_range(0, 1) != 0);
          pushed++;
        end
        1: begin
          cut = $urandom_range(1, fb);
          if (cut > n_items - pushed) cut = n_items - pushed;
          for (int k = 0; k < cut; k++) push_byte(pick_byte(), k == cut - 1);
          pushed += cut;
        end
        default: begin
          total = $urandom_range(1, 10) * fb;
          if (total > n_items - pushed) total = n_items - pushed;
          for (int k = 0; k < total; k++)
            push_byte(pick_byte(), (k == total - 1) && ($urandom_range(0, 3) != 0));
          pushed += total;
        end
      endcase
    end
  endtask

  // Pick a new register setting; upper data bits are random and must be ignored.
  task automatic pick_settings();
    logic [CFG_DATA_W-1:0] val;
    if ($urandom_range(0, 1) != 0) begin
      val = {15'($urandom), 2'($urandom_range(0, 3))};
      program_reg(REG_SAMPLE_WIDTH, val);
    end
    if ($urandom_range(0, 1) != 0) begin
      val = {13'($urandom), ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(1, 8))};
      program_reg(REG_CHANNEL_COUNT, val);
    end
    if ($urandom_range(0, 1) != 0) begin
      case ($urandom_range(0, 5))
        0:       val = 17'($urandom_range(0, 3));
        1:       val = 17'($urandom_range(4, 40));
        2:       val = 17'd65536;
        3:       val = 17'h1FFFF;
        4:       val = 17'd65535;
        default: val = 17'($urandom);
      endcase
      program_reg(REG_MAX_FRAMES, val);
    end
    if ($urandom_range(0, 5) == 0) program_reg(REG_UNLISTED, 17'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings, 16-bit mono: full-scale negative, full-scale positive,
    // minus one, then zero closing the data.
    push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
    wait_block_idle();

    // 8-bit unsigned, channel count zero (one channel), limit of two frames:
    // the third frame is dropped and its end of data clears the count.
    program_reg(REG_SAMPLE_WIDTH, CFG_DATA_W'(WIDTH_U8));
    program_reg(REG_CHANNEL_COUNT, 17'd0);
    program_reg(REG_MAX_FRAMES, 17'd2);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b1);
    wait_block_idle();

    // Spare width code, channel count past the maximum, limit past the cap.
    program_reg(REG_SAMPLE_WIDTH, CFG_DATA_W'(WIDTH_SPARE));
    program_reg(REG_CHANNEL_COUNT, 17'd15);
    program_reg(REG_MAX_FRAMES, 17'h1FFFF);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0); push_byte(8'h81, 1'b0);
    wait_block_idle();

    // 24-bit mono at both ends of the range.
    program_reg(REG_SAMPLE_WIDTH, CFG_DATA_W'(WIDTH_24));
    program_reg(REG_CHANNEL_COUNT, 17'd1);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h7F, 1'b1);
    wait_block_idle();

    // Random phases; drop all idling in the last few.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_settings();
      idling_on = (p < RANDOM_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);
      queue_random_phase(PHASE_ITEMS);
      wait_block_idle();
    end

    repeat (END_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
